### rtl/ssec_pkg.sv
package ssec_pkg;

  // Buffer depth and element width
  localparam int MAX_LEN    = 256;
  localparam int VALUE_BITS = 16;

  // Derived widths
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int ACC_W = VALUE_BITS + IDX_W;

  // Result field widths and limits
  localparam int SUM_W    = 24;
  localparam int COUNT_W  = 16;
  localparam int SUM_HI   = 8388607;
  localparam int SUM_LO   = -8388608;
  localparam int WIDE_W   = ACC_W + SUM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } ssec_state_t;

  // Clamp a running sum to the signed result range
  function automatic logic [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] s);
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    w  = WIDE_W'(s);
    hi = WIDE_W'(SUM_HI);
    lo = WIDE_W'(SUM_LO);
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return w[SUM_W-1:0];
  endfunction

  // Count up, holding at the top of the range
  function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

### rtl/ssec_ram.sv
module ssec_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/subarray_sum_extremes_counter_top.sv
// Loads a signed sequence one beat per cycle into an element RAM of MAX_LEN
// entries; the beat with last set closes the sequence. The block then walks
// every contiguous subarray, reading one element per cycle from the single
// read port of that RAM. Input is stalled during the computation and
// resumes as soon as the result sits in the output register. Elements beyond
// MAX_LEN are dropped and reported through overflow; the result's sums are
// saturated to 24 bits and its counts to 65535. min_count reads 0 when the
// smallest sum equals the largest.
module subarray_sum_extremes_counter_top
  import ssec_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SUM_W-1:0]   max_sum,
  output logic [COUNT_W-1:0]        max_count,
  output logic signed [SUM_W-1:0]   min_sum,
  output logic [COUNT_W-1:0]        min_count,
  output logic [COUNT_W-1:0]        zero_count,
  output logic [COUNT_W-1:0]        nonzero_count,
  output logic                      overflow
);

  ssec_state_t state, state_next;

  logic [CNT_W-1:0] total;
  logic             dropped;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic             in_acc;
  logic             scan_go;
  logic             scan_end;
  logic             res_load;

  // Read stage and sum stage
  logic                  p1_vld;
  logic                  p1_first;
  logic                  p1_fin;
  logic [VALUE_BITS-1:0] rd_data;
  logic signed [ACC_W-1:0] s;
  logic signed [ACC_W-1:0] s_base;
  logic signed [ACC_W-1:0] elem;
  logic                  s_vld;
  logic                  s_fin;

  // Running statistics
  logic                    seen;
  logic signed [ACC_W-1:0] hi;
  logic signed [ACC_W-1:0] lo;
  logic [COUNT_W-1:0]      hi_cnt;
  logic [COUNT_W-1:0]      lo_cnt;
  logic [COUNT_W-1:0]      zeros;
  logic [COUNT_W-1:0]      nonzeros;
  logic                    stats_done;

  assign in_acc   = in_valid && !in_stall;
  assign last_idx = total - CNT_W'(1);
  assign scan_end = (row == last_idx) && (col == last_idx);

  ssec_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && (total != CNT_W'(MAX_LEN))),
    .waddr (total[IDX_W-1:0]),
    .wdata (value),
    .raddr (col[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    scan_go    = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid && last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_go = 1'b1;
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stats_done && (!out_valid || !out_stall)) begin
          res_load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Buffer fill count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      dropped <= 1'b0;
    end else if (res_load) begin
      total   <= '0;
      dropped <= 1'b0;
    end else if (in_acc) begin
      if (total != CNT_W'(MAX_LEN)) begin
        total <= total + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // Walk start and end index over all subarrays
  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      row <= '0;
      col <= '0;
    end else if (scan_go) begin
      if (col == last_idx) begin
        row <= row + CNT_W'(1);
        col <= row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

  // Track the beat in flight through the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p1_fin <= 1'b0;
    end else begin
      p1_vld <= scan_go;
      p1_fin <= scan_go && scan_end;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= (col == row);
  end

  // Accumulate the running sum, restarting at each new start index
  assign elem   = ACC_W'($signed(rd_data));
  assign s_base = p1_first ? '0 : s;

  always_ff @(posedge clk) begin
    if (p1_vld) begin
      s <= s_base + elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
      s_fin <= 1'b0;
    end else begin
      s_vld <= p1_vld;
      s_fin <= p1_vld && p1_fin;
    end
  end

  // Update extremes and counts with each subarray sum
  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      stats_done <= 1'b0;
      zeros      <= '0;
      nonzeros   <= '0;
    end else if (in_acc && last) begin
      seen       <= 1'b0;
      stats_done <= 1'b0;
      zeros      <= '0;
      nonzeros   <= '0;
    end else begin
      if (s_vld) begin
        seen <= 1'b1;
        if (s == '0) begin
          zeros <= cnt_inc(zeros);
        end else begin
          nonzeros <= cnt_inc(nonzeros);
        end
      end
      if (s_fin) begin
        stats_done <= 1'b1;
      end else if (res_load) begin
        stats_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld) begin
      if (!seen || (s > hi)) begin
        hi     <= s;
        hi_cnt <= COUNT_W'(1);
      end else if (s == hi) begin
        hi_cnt <= cnt_inc(hi_cnt);
      end
      if (!seen || (s < lo)) begin
        lo     <= s;
        lo_cnt <= COUNT_W'(1);
      end else if (s == lo) begin
        lo_cnt <= cnt_inc(lo_cnt);
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      max_sum       <= sat_sum(hi);
      max_count     <= hi_cnt;
      min_sum       <= sat_sum(lo);
      min_count     <= (hi == lo) ? '0 : lo_cnt;
      zero_count    <= zeros;
      nonzero_count <= nonzeros;
      overflow      <= dropped;
    end
  end

endmodule

### rtl/ssec_checker.sv
module ssec_checker
  import ssec_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [VALUE_BITS-1:0] value,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [SUM_W-1:0]      max_sum,
  input logic [COUNT_W-1:0]           max_count,
  input logic signed [SUM_W-1:0]      min_sum,
  input logic [COUNT_W-1:0]           min_count,
  input logic [COUNT_W-1:0]           zero_count,
  input logic [COUNT_W-1:0]           nonzero_count,
  input logic                         overflow
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_sum) && $stable(min_sum))
    else $error("result changed while stalled");

  // Extremes are ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_sum >= min_sum)
    else $error("max_sum below min_sum");

  // min_count is zero exactly when the extremes coincide
  a_min_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((min_count == '0) == (max_sum == min_sum)))
    else $error("min_count inconsistent with extremes");

  // At least one subarray reaches the maximum
  a_max_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_count != '0)
    else $error("max_count is zero");

  // Closing a sequence starts the computation and stalls input
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input not stalled after last beat");

endmodule

bind subarray_sum_extremes_counter_top ssec_checker u_ssec_checker (.*);

### test/tb_subarray_sum_extremes_counter_top.sv
module tb_subarray_sum_extremes_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssec_pkg::*;

  typedef enum int {
    MIX_SMALL,
    MIX_FULL,
    MIX_EDGE,
    MIX_BLEND
  } value_mix_t;

  typedef struct {
    logic signed [SUM_W-1:0] max_sum;
    logic [COUNT_W-1:0]      max_count;
    logic signed [SUM_W-1:0] min_sum;
    logic [COUNT_W-1:0]      min_count;
    logic [COUNT_W-1:0]      zero_count;
    logic [COUNT_W-1:0]      nonzero_count;
    logic                    overflow;
  } extremes_t;

  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_PCT    = 17;
  localparam int DRAIN_TAIL  = 64;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         last = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SUM_W-1:0]      max_sum;
  logic [COUNT_W-1:0]           max_count;
  logic signed [SUM_W-1:0]      min_sum;
  logic [COUNT_W-1:0]           min_count;
  logic [COUNT_W-1:0]           zero_count;
  logic [COUNT_W-1:0]           nonzero_count;
  logic                         overflow;

  // Shadow copy of the sequence buffer
  int        seq_store [MAX_LEN];
  int        seq_len = 0;
  bit        seq_dropped = 1'b0;
  extremes_t expected_extremes [$];

  int mismatches = 0;
  int beats_sent = 0;
  bit calm = 1'b0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  subarray_sum_extremes_counter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .max_sum       (max_sum),
    .max_count     (max_count),
    .min_sum       (min_sum),
    .min_count     (min_count),
    .zero_count    (zero_count),
    .nonzero_count (nonzero_count),
    .overflow      (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #24_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [SUM_W-1:0] clamp_sum(longint s);
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(longint c);
    return (c > longint'(COUNT_MAX)) ? COUNT_MAX : c[COUNT_W-1:0];
  endfunction

  // Walk every contiguous subarray of the buffered sequence
  function automatic extremes_t tally_subarrays();
    extremes_t r;
    longint    hi = 0;
    longint    lo = 0;
    longint    acc;
    longint    hi_n = 0;
    longint    lo_n = 0;
    longint    zeros = 0;
    longint    total;
    bit        seen = 1'b0;
    for (int i = 0; i < seq_len; i++) begin
      acc = 0;
      for (int j = i; j < seq_len; j++) begin
        acc += seq_store[j];
        if (acc == 0) zeros++;
        if (!seen || acc > hi) begin
          hi   = acc;
          hi_n = 1;
        end else if (acc == hi) begin
          hi_n++;
        end
        if (!seen || acc < lo) begin
          lo   = acc;
          lo_n = 1;
        end else if (acc == lo) begin
          lo_n++;
        end
        seen = 1'b1;
      end
    end
    if (lo == hi) lo_n = 0;
    total = (longint'(seq_len) * (seq_len + 1)) / 2;
    r.max_sum       = clamp_sum(hi);
    r.max_count     = clamp_count(hi_n);
    r.min_sum       = clamp_sum(lo);
    r.min_count     = clamp_count(lo_n);
    r.zero_count    = clamp_count(zeros);
    r.nonzero_count = clamp_count(total - zeros);
    r.overflow      = seq_dropped;
    return r;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value(value_mix_t mix);
    value_mix_t m;
    m = mix;
    if (m == MIX_BLEND) m = value_mix_t'($urandom_range(2));
    case (m)
      MIX_SMALL: return VALUE_BITS'($urandom_range(6)) - VALUE_BITS'(3);
      MIX_EDGE: begin
        case ($urandom_range(4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      default:   return VALUE_BITS'($urandom());
    endcase
  endfunction

  // Offer one beat, hold it until accepted, then update the shadow buffer
  task automatic send_beat(logic signed [VALUE_BITS-1:0] v, bit l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (seq_len < MAX_LEN) begin
      seq_store[seq_len] = int'(v);
      seq_len++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (l) begin
      expected_extremes.insert(expected_extremes.size(), tally_subarrays());
      seq_len     = 0;
      seq_dropped = 1'b0;
    end
  endtask

  task automatic send_sequence(int len, value_mix_t mix);
    for (int i = 0; i < len; i++) send_beat(pick_value(mix), i == len - 1);
  endtask

  task automatic send_list(int vals[$]);
    foreach (vals[i]) send_beat(VALUE_BITS'(vals[i]), i == vals.size() - 1);
  endtask

  task automatic send_constant(int len, int v);
    for (int i = 0; i < len; i++) send_beat(VALUE_BITS'(v), i == len - 1);
  endtask

  // Drop valid and wait until every pending result has been seen
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_extremes.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_elements();
    send_constant(1, 32767);
    send_constant(1, -32768);
    send_constant(1, 0);
    send_constant(1, 1);
    wait_drain();
  endtask

  task automatic test_short_patterns();
    int pat[$];
    pat = '{1, -1};
    send_list(pat);
    pat = '{5, 5, 5};
    send_list(pat);
    pat = '{0, 0, 0};
    send_list(pat);
    pat = '{-32768, -32768, 32767, 32767};
    send_list(pat);
    pat = '{3, -3, 3, -3, 3};
    send_list(pat);
    pat = '{-1, 2, -1};
    send_list(pat);
    wait_drain();
  endtask

  // Fill the buffer exactly, then run past it so trailing beats are dropped
  task automatic test_full_buffer();
    send_constant(MAX_LEN, 32767);
    send_constant(MAX_LEN, -32768);
    send_sequence(MAX_LEN + 1, MIX_FULL);
    send_sequence(MAX_LEN + 44, MIX_BLEND);
    send_sequence(3, MIX_SMALL);
    wait_drain();
  endtask

  task automatic test_random_sequences(int budget);
    int         start;
    int         len;
    int         r;
    value_mix_t mix;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(8, 1);
      else if (r < 95) len = $urandom_range(24, 9);
      else len = $urandom_range(64, 25);
      mix = value_mix_t'($urandom_range(3));
      send_sequence(len, mix);
    end
    wait_drain();
  endtask

  // Run without any idle cycles on either side
  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_sequences(150);
    calm = 1'b0;
  endtask

  // Hold the result port off while short sequences keep arriving
  task automatic test_result_backpressure();
    hold_ticket <= hold_ticket + 1;
    for (int k = 0; k < 12; k++) send_sequence($urandom_range(6, 1), MIX_BLEND);
    wait_drain();
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin : drive_out_stall
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    extremes_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_extremes.size() == 0) begin
        $error("result beat with no pending expectation");
        mismatches++;
      end else begin
        want = expected_extremes.pop_front();
        check_field("max_sum", want.max_sum, max_sum);
        check_field("max_count", want.max_count, max_count);
        check_field("min_sum", want.min_sum, min_sum);
        check_field("min_count", want.min_count, min_count);
        check_field("zero_count", want.zero_count, zero_count);
        check_field("nonzero_count", want.nonzero_count, nonzero_count);
        check_field("overflow", want.overflow, overflow);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_elements();
    test_short_patterns();
    test_full_buffer();
    test_steady_stream();
    test_result_backpressure();
    test_random_sequences(120);
    test_result_backpressure();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && expected_extremes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
